/* rtl/core/fsa_pkg.sv */
// ============================================================================
// fsa_pkg
// Shared types and constants of the fit strategy allocator.
// ============================================================================
package fsa_pkg;

    // Default number of allocation map entries.
    localparam int MAP_DEPTH_DEF = 4096;

    // Widths of the fixed fields.
    localparam int ADDR_W    = 16;
    localparam int VALUE_W   = 4;
    localparam int SIZE_W    = 16;
    localparam int HSIZE_W   = 13;
    localparam int STRAT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 40;

    // Register values after reset.
    localparam logic [HSIZE_W-1:0] HEAP_SIZE_RST = 13'd4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE  = 2'd2;

    // Strategy codes.
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd3;

    // Item functions.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } fsa_state_t;

endpackage

/* rtl/core/fsa_ram.sv */
// ============================================================================
// fsa_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
module fsa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/fit_strategy_allocator_top.sv */
// ============================================================================
// fit_strategy_allocator_top
// Allocation map with first, next, best and worst fit searches for free runs.
// ============================================================================
//
// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ---------------------------------------
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: entry_addr,
//                                   entry_value, request_size
// m_*       out  m_tvalid/m_tready  tuser: found; tdata: block_start
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// After reset the block sweeps the map to free, one entry a cycle, through
// all MAP_DEPTH entries, and accepts no item meanwhile. A write item writes
// its entry when it is accepted and then passes through ST_RESP. A search
// item reads the map one entry a cycle through the single RAM port. A pass
// from start offset f reads up to the area end plus an end mark, and the
// result goes through the result registers and ST_RESP into the output
// register. First fit stops at the first fitting run, and next fit may add
// a second pass from the start of the area. One item is at work at a time;
// a new item is accepted while the previous result still waits in the output
// register, and a finished result waits in ST_RESP until the output register
// is empty or taken by m_tready before the block goes idle again.
// ============================================================================
module fit_strategy_allocator_top #(
    parameter int MAP_DEPTH = fsa_pkg::MAP_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fsa_pkg::S_DATA_W-1:0]    s_tdata,   // entry_addr[15:0],
                                                       // entry_value[19:16],
                                                       // request_size[35:20],
                                                       // zero pad [39:36]
    input  logic                            s_tuser,   // func
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsa_pkg::ADDR_W-1:0]      m_tdata,   // block_start[15:0]
    output logic                            m_tuser,   // found
    // Configuration writes.
    input  logic                            cfg_we,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsa_pkg::CFG_W-1:0]       cfg_data
);

    import fsa_pkg::*;

    // Map index width, and a count width that holds MAP_DEPTH + 1.
    localparam int AW = $clog2(MAP_DEPTH);
    localparam int CW = $clog2(MAP_DEPTH + 2);

    // Input item fields.
    logic [ADDR_W-1:0]  in_addr;
    logic [VALUE_W-1:0] in_value;
    logic [SIZE_W-1:0]  in_size;

    assign in_addr  = s_tdata[15:0];
    assign in_value = s_tdata[19:16];
    assign in_size  = s_tdata[35:20];

    // Configuration registers.
    logic [STRAT_W-1:0] strategy_reg;
    logic [ADDR_W-1:0]  heap_start_reg;
    logic [HSIZE_W-1:0] heap_size_reg;

    // Control and scan state.
    fsa_state_t         state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [CW-1:0]      pend_idx_reg, pend_idx_next;
    logic [CW-1:0]      run_st_reg, run_st_next;
    logic [CW-1:0]      run_len_reg, run_len_next;
    logic [CW-1:0]      pick_st_reg, pick_st_next;
    logic [CW-1:0]      pick_len_reg, pick_len_next;
    logic               have_reg, have_next;
    logic               pass_reg, pass_next;
    logic [CW-1:0]      need_reg, need_next;
    logic [CW-1:0]      from_reg, from_next;
    logic [ADDR_W-1:0]  nfp_reg, nfp_next;
    logic               res_found_reg, res_found_next;
    logic [ADDR_W-1:0]  res_start_reg, res_start_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [ADDR_W-1:0]  m_start_reg, m_start_next;

    // RAM port.
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;

    fsa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Length of the searched area: heap_size capped at the map depth.
    logic [CW-1:0]     lim;
    // Write item target offset and whether it falls inside the map.
    logic [ADDR_W-1:0] wr_idx;
    logic              wr_ok;
    // Next-fit starting offset, moved to the area start when stale.
    logic [ADDR_W-1:0] nf_diff;
    logic [CW-1:0]     nf_from;
    logic              req_bad;
    logic              accept;
    logic              out_free;
    logic              first_mode;

    always_comb
    begin
        if (32'(heap_size_reg) > 32'(MAP_DEPTH))
        begin
            lim = CW'(MAP_DEPTH);
        end
        else
        begin
            lim = CW'(heap_size_reg);
        end
    end

    assign wr_idx     = in_addr - heap_start_reg;
    assign wr_ok      = 32'(wr_idx) < 32'(MAP_DEPTH);
    assign nf_diff    = nfp_reg - heap_start_reg;
    assign nf_from    = (32'(nf_diff) >= 32'(lim)) ? '0 : CW'(nf_diff);
    assign req_bad    = (in_size == '0) || (32'(in_size) > 32'(lim));
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign first_mode = (strategy_reg == STRAT_FIRST) || (strategy_reg == STRAT_NEXT);

    // Processing of the map entry whose read data arrives this cycle.
    logic          cur_free;
    logic [CW-1:0] cur_st;
    logic [CW-1:0] cur_len;
    logic          cur_hit;
    logic          cur_fits;
    logic          cur_take;
    logic          pass_end;

    always_comb
    begin
        cur_free = (pend_idx_reg < lim) && (ram_rdata == '0);
        cur_st   = (run_len_reg == '0) ? pend_idx_reg : run_st_reg;
        cur_len  = run_len_reg + 1'b1;
        cur_hit  = pend_valid_reg && cur_free && first_mode && (cur_len >= need_reg);
        cur_fits = run_len_reg >= need_reg;
        cur_take = cur_fits && (!have_reg
                   || ((strategy_reg == STRAT_BEST) && (run_len_reg < pick_len_reg))
                   || ((strategy_reg == STRAT_WORST) && (run_len_reg > pick_len_reg)));
        pass_end = pend_valid_reg && !cur_free && (pend_idx_reg == lim);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MAP_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_SEARCH && !req_bad)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cur_hit)
                begin
                    state_next = ST_RESP;
                end
                else if (pass_end)
                begin
                    if (!(first_mode && strategy_reg == STRAT_NEXT && !pass_reg
                          && from_reg != '0))
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and RAM port.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = issue_reg[AW-1:0];
        ram_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept && s_tuser == FUNC_WRITE && wr_ok)
                begin
                    ram_we    = 1'b1;
                    ram_addr  = wr_idx[AW-1:0];
                    ram_wdata = in_value;
                end
            end
            default:
            begin
                ram_addr = issue_reg[AW-1:0];
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        run_st_next     = run_st_reg;
        run_len_next    = run_len_reg;
        pick_st_next    = pick_st_reg;
        pick_len_next   = pick_len_reg;
        have_next       = have_reg;
        pass_next       = pass_reg;
        need_next       = need_reg;
        from_next       = from_reg;
        nfp_next        = nfp_reg;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_found_next    = m_found_reg;
        m_start_next    = m_start_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                res_found_next = 1'b0;
                res_start_next = '0;
                if (accept && s_tuser == FUNC_SEARCH && !req_bad)
                begin
                    need_next     = CW'(in_size);
                    from_next     = (strategy_reg == STRAT_NEXT) ? nf_from : '0;
                    issue_next    = (strategy_reg == STRAT_NEXT) ? nf_from : '0;
                    run_len_next  = '0;
                    have_next     = 1'b0;
                    pass_next     = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Issue one map read a cycle up to and including the end mark.
                if (issue_reg <= lim)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg;
                    issue_next      = issue_reg + 1'b1;
                end

                if (pend_valid_reg)
                begin
                    if (cur_free)
                    begin
                        run_st_next  = cur_st;
                        run_len_next = cur_len;
                    end
                    else
                    begin
                        run_len_next = '0;
                        if (cur_take)
                        begin
                            have_next     = 1'b1;
                            pick_st_next  = run_st_reg;
                            pick_len_next = run_len_reg;
                        end
                    end
                end

                if (cur_hit)
                begin
                    res_found_next = 1'b1;
                    res_start_next = heap_start_reg + ADDR_W'(cur_st);
                    if (strategy_reg == STRAT_NEXT)
                    begin
                        nfp_next = heap_start_reg + ADDR_W'(cur_st) + ADDR_W'(need_reg);
                    end
                end
                else if (pass_end)
                begin
                    if (strategy_reg == STRAT_NEXT && !pass_reg && from_reg != '0)
                    begin
                        // Next fit found nothing from the stored position:
                        // search the whole area from its start.
                        pass_next       = 1'b1;
                        issue_next      = '0;
                        pend_valid_next = 1'b0;
                        run_len_next    = '0;
                    end
                    else if (cur_take)
                    begin
                        res_found_next = 1'b1;
                        res_start_next = heap_start_reg + ADDR_W'(run_st_reg);
                    end
                    else if (have_reg)
                    begin
                        res_found_next = 1'b1;
                        res_start_next = heap_start_reg + ADDR_W'(pick_st_reg);
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_start_next = res_start_reg;
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            nfp_reg        <= '0;
            strategy_reg   <= STRAT_FIRST;
            heap_start_reg <= '0;
            heap_size_reg  <= HEAP_SIZE_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            nfp_reg        <= nfp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STRATEGY:   strategy_reg   <= cfg_data[STRAT_W-1:0];
                    CFG_HEAP_START: heap_start_reg <= cfg_data[ADDR_W-1:0];
                    CFG_HEAP_SIZE:  heap_size_reg  <= cfg_data[HSIZE_W-1:0];
                    default:        strategy_reg   <= strategy_reg;
                endcase
            end
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        run_st_reg    <= run_st_next;
        run_len_reg   <= run_len_next;
        pick_st_reg   <= pick_st_next;
        pick_len_reg  <= pick_len_next;
        have_reg      <= have_next;
        pass_reg      <= pass_next;
        need_reg      <= need_next;
        from_reg      <= from_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        m_found_reg   <= m_found_next;
        m_start_reg   <= m_start_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_start_reg;

endmodule
